FILE: hdl/balance_cascade_pid_top_macros.svh
// Assertion macros for the balance controller checker.
// Used by hdl/bcp_checker.sv; no other dependencies.
`ifndef BALANCE_CASCADE_PID_TOP_MACROS_SVH
`define BALANCE_CASCADE_PID_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define BCP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define BCP_ASSERT_NR(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

FILE: hdl/bcp_pkg.sv
// Shared types, constants and the microcode table of the balance controller.
// No dependencies; imported by bcp_useq and balance_cascade_pid_top.
`default_nettype none

package bcp_pkg;

  // Speed loop runs once every SPEED_DECIMATION upright ticks (1..64)
  localparam int SPEED_DECIMATION = 8;
  localparam int TICK_W = (SPEED_DECIMATION > 1) ? $clog2(SPEED_DECIMATION) : 1;

  // Port and storage widths
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;
  localparam int GAIN_W    = 20;
  localparam int BIAS_W    = 24;
  localparam int SUM_W     = 20;
  localparam int MA_W      = 32;
  localparam int MB_W      = GAIN_W;
  localparam int PROD_W    = MA_W + MB_W;
  localparam int ACC_W     = 64;
  localparam int INT_W     = 26;
  localparam int CORR_W    = 21;
  localparam int ANG_W     = 52;
  localparam int PC_W      = 5;

  // Register index map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_KP   = 3'd0,
    CFG_ANGLE_KD   = 3'd1,
    CFG_SPEED_KP   = 3'd2,
    CFG_SPEED_KI   = 3'd3,
    CFG_TURN_KP    = 3'd4,
    CFG_TURN_KD    = 3'd5,
    CFG_BIAS_PITCH = 3'd6,
    CFG_BIAS_YAW   = 3'd7
  } cfg_idx_t;

  // Multiplier operand A sources
  typedef enum logic [2:0] {
    A_SF, A_ERR, A_INT, A_PITCH, A_PRATE, A_TTURN, A_YRATE
  } a_sel_t;

  // Multiplier operand B sources
  typedef enum logic [3:0] {
    B_KEEP, B_NEW, B_KINT, B_SKP, B_SKI, B_AKP, B_AKD, B_TKP, B_TKD
  } b_sel_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_SUMS, WB_SF, WB_INT, WB_CORR, WB_ANG, WB_OUT, WB_FALL
  } wb_op_t;

  typedef enum logic [1:0] {FL_NEXT, FL_DISPATCH, FL_END} flow_t;

  // Program steps
  typedef enum logic [PC_W-1:0] {
    ST_DISPATCH, ST_SF_MK, ST_ERR_MK, ST_SF_ACC, ST_SF_WB,
    ST_INT_MK, ST_INT_LD, ST_INT_WB, ST_CP_MK, ST_CI_MK,
    ST_C_ACC, ST_C_WB, ST_AP_MK, ST_AD_MK, ST_A_ACC,
    ST_A_WB, ST_TD_MK, ST_T_ACC, ST_OUT, ST_FALL
  } step_t;

  // One control word of the program
  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    logic    sh8;
    acc_op_t acc_op;
    wb_op_t  wb_op;
    flow_t   flow;
  } cw_t;

  // Branch conditions seen by the sequencer
  typedef struct packed {
    logic fallen;
    logic decim;
  } status_t;

  function automatic cw_t mk(input a_sel_t a, input b_sel_t b, input logic s,
                             input acc_op_t ac, input wb_op_t wb, input flow_t fl);
    cw_t c;
    c.a_sel  = a;
    c.b_sel  = b;
    c.sh8    = s;
    c.acc_op = ac;
    c.wb_op  = wb;
    c.flow   = fl;
    return c;
  endfunction

  // Microcode ROM. The product register loads on every step, the
  // accumulator takes the product of the previous step.
  function automatic cw_t ucode(input logic [PC_W-1:0] pc);
    cw_t c;
    unique case (step_t'(pc))
      ST_DISPATCH: c = mk(A_SF,    B_KEEP, 1'b0, ACC_HOLD, WB_SUMS, FL_DISPATCH);
      ST_SF_MK:    c = mk(A_SF,    B_KEEP, 1'b0, ACC_HOLD, WB_NONE, FL_NEXT);
      ST_ERR_MK:   c = mk(A_ERR,   B_NEW,  1'b1, ACC_LOAD, WB_NONE, FL_NEXT);
      ST_SF_ACC:   c = mk(A_SF,    B_KEEP, 1'b0, ACC_ADD,  WB_NONE, FL_NEXT);
      ST_SF_WB:    c = mk(A_SF,    B_KEEP, 1'b0, ACC_HOLD, WB_SF,   FL_NEXT);
      ST_INT_MK:   c = mk(A_SF,    B_KINT, 1'b0, ACC_HOLD, WB_NONE, FL_NEXT);
      ST_INT_LD:   c = mk(A_SF,    B_KINT, 1'b0, ACC_LOAD, WB_NONE, FL_NEXT);
      ST_INT_WB:   c = mk(A_SF,    B_KINT, 1'b0, ACC_HOLD, WB_INT,  FL_NEXT);
      ST_CP_MK:    c = mk(A_SF,    B_SKP,  1'b0, ACC_HOLD, WB_NONE, FL_NEXT);
      ST_CI_MK:    c = mk(A_INT,   B_SKI,  1'b0, ACC_LOAD, WB_NONE, FL_NEXT);
      ST_C_ACC:    c = mk(A_INT,   B_SKI,  1'b0, ACC_ADD,  WB_NONE, FL_NEXT);
      ST_C_WB:     c = mk(A_INT,   B_SKI,  1'b0, ACC_HOLD, WB_CORR, FL_NEXT);
      ST_AP_MK:    c = mk(A_PITCH, B_AKP,  1'b0, ACC_HOLD, WB_NONE, FL_NEXT);
      ST_AD_MK:    c = mk(A_PRATE, B_AKD,  1'b1, ACC_LOAD, WB_NONE, FL_NEXT);
      ST_A_ACC:    c = mk(A_PRATE, B_AKD,  1'b1, ACC_ADD,  WB_NONE, FL_NEXT);
      ST_A_WB:     c = mk(A_TTURN, B_TKP,  1'b1, ACC_HOLD, WB_ANG,  FL_NEXT);
      ST_TD_MK:    c = mk(A_YRATE, B_TKD,  1'b1, ACC_LOAD, WB_NONE, FL_NEXT);
      ST_T_ACC:    c = mk(A_YRATE, B_TKD,  1'b1, ACC_ADD,  WB_NONE, FL_NEXT);
      ST_OUT:      c = mk(A_YRATE, B_TKD,  1'b1, ACC_HOLD, WB_OUT,  FL_END);
      ST_FALL:     c = mk(A_SF,    B_KEEP, 1'b0, ACC_HOLD, WB_FALL, FL_END);
      default:     c = mk(A_SF,    B_KEEP, 1'b0, ACC_HOLD, WB_NONE, FL_END);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bcp_useq.sv
// Step counter and control ROM sequencer of the balance controller.
// Depends on bcp_pkg (control word, status and step types).
`default_nettype none

module bcp_useq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            stall,
  input  wire bcp_pkg::status_t status,
  output logic                 busy,
  output logic                 fire,
  output bcp_pkg::cw_t         cw
);
  import bcp_pkg::*;

  logic [PC_W-1:0] pc, pc_next;
  logic            busy_next;

  assign cw   = ucode(pc);
  assign fire = busy && !stall;

  // Next step: sequential, branch at dispatch, stop at end
  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (!busy) begin
      if (start) begin
        busy_next = 1'b1;
        pc_next   = ST_DISPATCH;
      end
    end else if (fire) begin
      unique case (cw.flow)
        FL_NEXT: pc_next = pc + PC_W'(1);
        FL_DISPATCH: begin
          if (status.fallen)     pc_next = ST_FALL;
          else if (status.decim) pc_next = pc + PC_W'(1);
          else                   pc_next = ST_AP_MK;
        end
        FL_END:  busy_next = 1'b0;
        default: busy_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= ST_DISPATCH;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/balance_cascade_pid_top.sv
// Cascaded speed-PI / angle-PD / turn controller; depends on bcp_pkg and bcp_useq.
// A fallen tick goes straight to its output step; a plain tick runs the angle and
// turn steps, and a speed-loop tick runs the speed steps first, all on the one shared
// 32x20 multiplier. Throughput: one tick in flight, the next accepted only when the
// sequencer is idle; a result left waiting holds the next tick at its output step.
// Reset (rst, synchronous, active high) loads default gains and clears all loop state.
`default_nettype none

module balance_cascade_pid_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [bcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bcp_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [16:0]              pitch_angle,
  input  wire logic signed [23:0]              pitch_rate,
  input  wire logic signed [23:0]              yaw_rate,
  input  wire logic signed [15:0]              left_count,
  input  wire logic signed [15:0]              right_count,
  input  wire logic signed [14:0]              target_speed,
  input  wire logic signed [13:0]              target_turn,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [8:0]                    left_pwm,
  output logic signed [8:0]                    right_pwm,
  output logic                                 fallen
);
  import bcp_pkg::*;

  localparam logic signed [16:0]      FALL_LIMIT = 17'sd7680;
  localparam logic [TICK_W-1:0]       TICK_LAST  = TICK_W'(SPEED_DECIMATION - 1);
  localparam logic signed [MB_W-1:0]  K_KEEP     = 20'sd45875;
  localparam logic signed [MB_W-1:0]  K_NEW      = 20'sd19661;
  localparam logic signed [MB_W-1:0]  K_INT      = 20'sd2621;
  localparam logic signed [ACC_W-1:0] INT_LIMIT  = 64'sd26214400;
  localparam logic signed [ACC_W-1:0] CORR_LIMIT = 64'sd655360;
  localparam logic signed [ACC_W-1:0] S32_MAX    = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] S32_MIN    = -64'sd2147483648;

  // Truncate a Q16.16 value toward zero and saturate to the PWM range
  function automatic logic signed [8:0] pwm_sat(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] q;
    if (x < 0) q = (x + 64'sd65535) >>> 16;
    else       q = x >>> 16;
    if (q > 64'sd255)       return 9'sd255;
    else if (q < -64'sd255) return -9'sd255;
    else                    return q[8:0];
  endfunction

  // Configuration registers
  logic signed [GAIN_W-1:0] angle_kp, angle_kd, speed_kp, speed_ki, turn_kp, turn_kd;
  logic signed [BIAS_W-1:0] bias_pitch, bias_yaw;

  // Loop state
  logic signed [31:0]       speed_filtered;
  logic signed [INT_W-1:0]  speed_integral;
  logic signed [SUM_W-1:0]  left_sum, right_sum;
  logic [TICK_W-1:0]        tick_count;
  logic signed [CORR_W-1:0] speed_correction;

  // Latched transaction
  logic signed [16:0] pitch_q;
  logic signed [23:0] prate_q, yrate_q;
  logic signed [15:0] lc_q, rc_q;
  logic signed [14:0] tspeed_q;
  logic signed [13:0] tturn_q;

  // Datapath registers
  logic signed [ACC_W-1:0] prod, acc;
  logic signed [ANG_W-1:0] angle_out;

  // Sequencer
  logic    busy, fire, stall, start, out_step;
  cw_t     cw;
  status_t status;

  assign in_ready = !busy;
  assign start    = in_valid && in_ready;
  assign out_step = (cw.wb_op == WB_OUT) || (cw.wb_op == WB_FALL);
  assign stall    = busy && out_step && out_valid && !out_ready;

  assign status.fallen = (pitch_q > FALL_LIMIT) || (pitch_q < -FALL_LIMIT);
  assign status.decim  = (tick_count == TICK_LAST);

  bcp_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stall  (stall),
    .status (status),
    .busy   (busy),
    .fire   (fire),
    .cw     (cw)
  );

  // Operand preparation
  logic signed [20:0] sum2;
  logic signed [28:0] err_op;
  logic signed [25:0] pitch_op;
  logic signed [24:0] prate_op, yrate_op;
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [PROD_W-1:0] mul_p;

  assign sum2     = 21'(left_sum) + 21'(right_sum);
  // speed error scaled down by 256: sum*128 - target_speed
  assign err_op   = {sum2[20], sum2, 7'b0} - 29'(tspeed_q);
  // pitch*256 - target, target = -1.0 - correction
  assign pitch_op = {pitch_q[16], pitch_q, 8'b0} + 26'sd65536 + 26'(speed_correction);
  assign prate_op = {prate_q[23], prate_q} - {bias_pitch[23], bias_pitch};
  assign yrate_op = {yrate_q[23], yrate_q} - {bias_yaw[23], bias_yaw};

  always_comb begin
    case (cw.a_sel)
      A_SF:    ma = speed_filtered;
      A_ERR:   ma = MA_W'(err_op);
      A_INT:   ma = MA_W'(speed_integral);
      A_PITCH: ma = MA_W'(pitch_op);
      A_PRATE: ma = MA_W'(prate_op);
      A_TTURN: ma = MA_W'(tturn_q);
      A_YRATE: ma = MA_W'(yrate_op);
      default: ma = speed_filtered;
    endcase
  end

  always_comb begin
    case (cw.b_sel)
      B_KEEP:  mb = K_KEEP;
      B_NEW:   mb = K_NEW;
      B_KINT:  mb = K_INT;
      B_SKP:   mb = speed_kp;
      B_SKI:   mb = speed_ki;
      B_AKP:   mb = angle_kp;
      B_AKD:   mb = angle_kd;
      B_TKP:   mb = turn_kp;
      B_TKD:   mb = turn_kd;
      default: mb = K_KEEP;
    endcase
  end

  assign mul_p = ma * mb;

  // Rounded results of the accumulator
  logic signed [ACC_W-1:0] r16, r12, int_sum, lmix, rmix;
  assign r16     = (acc + 64'sd32768) >>> 16;
  assign r12     = (acc + 64'sd2048) >>> 12;
  assign int_sum = ACC_W'(speed_integral) + r16;
  assign lmix    = ACC_W'(angle_out) + r12;
  assign rmix    = ACC_W'(angle_out) - r12;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_kp   <= -20'sd81920;
      angle_kd   <= -20'sd410;
      speed_kp   <= -20'sd1229;
      speed_ki   <= -20'sd41;
      turn_kp    <= 20'sd4915;
      turn_kd    <= 20'sd2048;
      bias_pitch <= '0;
      bias_yaw   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ANGLE_KP:   angle_kp   <= cfg_data[GAIN_W-1:0];
        CFG_ANGLE_KD:   angle_kd   <= cfg_data[GAIN_W-1:0];
        CFG_SPEED_KP:   speed_kp   <= cfg_data[GAIN_W-1:0];
        CFG_SPEED_KI:   speed_ki   <= cfg_data[GAIN_W-1:0];
        CFG_TURN_KP:    turn_kp    <= cfg_data[GAIN_W-1:0];
        CFG_TURN_KD:    turn_kd    <= cfg_data[GAIN_W-1:0];
        CFG_BIAS_PITCH: bias_pitch <= cfg_data[BIAS_W-1:0];
        CFG_BIAS_YAW:   bias_yaw   <= cfg_data[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (start) begin
      pitch_q  <= pitch_angle;
      prate_q  <= pitch_rate;
      yrate_q  <= yaw_rate;
      lc_q     <= left_count;
      rc_q     <= right_count;
      tspeed_q <= target_speed;
      tturn_q  <= target_turn;
    end
  end

  // Multiplier and accumulator
  always_ff @(posedge clk) begin
    if (fire) begin
      prod <= cw.sh8 ? (ACC_W'(mul_p) <<< 8) : ACC_W'(mul_p);
      case (cw.acc_op)
        ACC_LOAD: acc <= prod;
        ACC_ADD:  acc <= acc + prod;
        default:  ;
      endcase
      if (cw.wb_op == WB_ANG) angle_out <= r12[ANG_W-1:0];
    end
  end

  // Loop state write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_filtered   <= '0;
      speed_integral   <= '0;
      left_sum         <= '0;
      right_sum        <= '0;
      tick_count       <= '0;
      speed_correction <= '0;
    end else if (fire) begin
      case (cw.wb_op)
        WB_SUMS: begin
          if (!status.fallen) begin
            left_sum  <= left_sum + SUM_W'(lc_q);
            right_sum <= right_sum + SUM_W'(rc_q);
            if (!status.decim) tick_count <= tick_count + TICK_W'(1);
          end
        end
        WB_SF: begin
          if (r16 > S32_MAX)      speed_filtered <= 32'sh7fffffff;
          else if (r16 < S32_MIN) speed_filtered <= 32'sh80000000;
          else                    speed_filtered <= r16[31:0];
        end
        WB_INT: begin
          if (int_sum > INT_LIMIT)       speed_integral <= INT_W'(INT_LIMIT);
          else if (int_sum < -INT_LIMIT) speed_integral <= INT_W'(-INT_LIMIT);
          else                           speed_integral <= int_sum[INT_W-1:0];
        end
        WB_CORR: begin
          if (r12 > CORR_LIMIT)       speed_correction <= CORR_W'(CORR_LIMIT);
          else if (r12 < -CORR_LIMIT) speed_correction <= CORR_W'(-CORR_LIMIT);
          else                        speed_correction <= r12[CORR_W-1:0];
          left_sum   <= '0;
          right_sum  <= '0;
          tick_count <= '0;
        end
        WB_FALL: speed_integral <= '0;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && out_step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (cw.wb_op == WB_OUT)) begin
      left_pwm  <= pwm_sat(lmix);
      right_pwm <= pwm_sat(rmix);
      fallen    <= 1'b0;
    end else if (fire && (cw.wb_op == WB_FALL)) begin
      left_pwm  <= '0;
      right_pwm <= '0;
      fallen    <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bcp_checker.sv
// Port-level checker for balance_cascade_pid_top, attached by bind.
// Depends on balance_cascade_pid_top_macros.svh.
`default_nettype none

`include "balance_cascade_pid_top_macros.svh"

module bcp_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [8:0] left_pwm,
  input wire logic signed [8:0] right_pwm,
  input wire logic              fallen
);

  // A fallen result always stops both motors
  `BCP_ASSERT(a_fallen_stops, clk, rst, out_valid && fallen |-> left_pwm == 9'sd0 && right_pwm == 9'sd0, "fallen result with nonzero drive")

  // Drives never reach the one code outside the saturated range
  `BCP_ASSERT(a_pwm_range, clk, rst, out_valid |-> left_pwm != 9'h100 && right_pwm != 9'h100, "drive outside +-255")

  // One tick in flight: the input side closes after each accepted transaction
  `BCP_ASSERT(a_one_in_flight, clk, rst, in_valid && in_ready |=> !in_ready, "input accepted while busy")

  // A pending result holds until taken
  `BCP_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(left_pwm) && $stable(right_pwm) && $stable(fallen), "pending result changed")

  // No result is presented right after reset
  `BCP_ASSERT_NR(a_reset_quiet, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind balance_cascade_pid_top bcp_checker u_bcp_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for balance_cascade_pid_top: random and directed control ticks,
// a bit-accurate tick predictor, and a result scoreboard. Depends on bcp_pkg.
`default_nettype none

module testbench;
  import bcp_pkg::*;

  // One control tick as presented on the input channel
  typedef struct {
    logic signed [16:0] pitch_angle;
    logic signed [23:0] pitch_rate;
    logic signed [23:0] yaw_rate;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
    logic signed [14:0] target_speed;
    logic signed [13:0] target_turn;
  } tick_in_t;

  // Motor drive result of one tick
  typedef struct {
    logic signed [8:0] left_pwm;
    logic signed [8:0] right_pwm;
    logic              fallen;
  } pwm_result_t;

  typedef enum {MODE_CRUISE, MODE_PUSH, MODE_TUMBLE, MODE_NOISE} drive_mode_t;

  localparam longint Q_ONE      = 65536;
  localparam longint TILT_LIMIT = 7680;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [16:0] pitch_angle = '0;
  logic signed [23:0] pitch_rate = '0;
  logic signed [23:0] yaw_rate = '0;
  logic signed [15:0] left_count = '0;
  logic signed [15:0] right_count = '0;
  logic signed [14:0] target_speed = '0;
  logic signed [13:0] target_turn = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [8:0] left_pwm;
  logic signed [8:0] right_pwm;
  logic fallen;

  balance_cascade_pid_top dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .pitch_angle, .pitch_rate, .yaw_rate, .left_count, .right_count,
    .target_speed, .target_turn,
    .out_valid, .out_ready, .left_pwm, .right_pwm, .fallen
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #8000000;
    $display("testbench failed");
    $finish;
  end

  // Predictor copy of the gains and loop state
  longint gain_r [0:7] = '{-81920, -410, -1229, -41, 4915, 2048, 0, 0};
  longint spd_filt = 0;
  longint spd_int = 0;
  longint spd_corr = 0;
  logic signed [19:0] lsum = '0;
  logic signed [19:0] rsum = '0;
  int ticks_since_loop = 0;

  tick_in_t tick_q[$];
  pwm_result_t pwm_expected[$];
  tick_in_t held_tick;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_off = 0;
  int results_seen = 0;
  int mismatches = 0;
  bit no_idle = 1'b0;

  // Round to nearest, halves up, then drop n fraction bits
  function automatic longint rnd_shift(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_mag(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Speed PI, run every SPEED_DECIMATION upright ticks
  function automatic void speed_pi(longint tspeed);
    longint speed, err, f, corr;
    speed = (longint'(lsum) + longint'(rsum)) * (Q_ONE / 2);
    err = speed - tspeed * 256;
    f = rnd_shift(spd_filt * 45875 + err * 19661, 16);
    if (f > 64'sd2147483647) f = 64'sd2147483647;
    if (f < -64'sd2147483648) f = -64'sd2147483648;
    spd_filt = f;
    spd_int = clamp_mag(spd_int + rnd_shift(f * 2621, 16), 400 * Q_ONE);
    corr = rnd_shift(gain_r[CFG_SPEED_KP] * f + gain_r[CFG_SPEED_KI] * spd_int, 12);
    spd_corr = clamp_mag(corr, 10 * Q_ONE);
    lsum = '0;
    rsum = '0;
    ticks_since_loop = 0;
  endfunction

  // Expected drive for one tick; updates the predictor state
  function automatic pwm_result_t balance_tick(tick_in_t t);
    pwm_result_t r;
    longint p, target, ang, trn, l, rr;
    p = t.pitch_angle;
    if (p > TILT_LIMIT || p < -TILT_LIMIT) begin
      spd_int = 0;
      r.left_pwm = '0;
      r.right_pwm = '0;
      r.fallen = 1'b1;
      return r;
    end
    lsum = lsum + t.left_count;
    rsum = rsum + t.right_count;
    if (ticks_since_loop + 1 >= SPEED_DECIMATION) speed_pi(t.target_speed);
    else ticks_since_loop++;
    target = -Q_ONE - spd_corr;
    ang = rnd_shift(gain_r[CFG_ANGLE_KP] * (p * 256 - target) +
                    gain_r[CFG_ANGLE_KD] * ((longint'(t.pitch_rate) -
                                             gain_r[CFG_BIAS_PITCH]) * 256), 12);
    trn = rnd_shift(gain_r[CFG_TURN_KP] * (longint'(t.target_turn) * 256) +
                    gain_r[CFG_TURN_KD] * ((longint'(t.yaw_rate) -
                                            gain_r[CFG_BIAS_YAW]) * 256), 12);
    l = clamp_mag((ang + trn) / Q_ONE, 255);
    rr = clamp_mag((ang - trn) / Q_ONE, 255);
    r.left_pwm = l[8:0];
    r.right_pwm = rr[8:0];
    r.fallen = 1'b0;
    return r;
  endfunction

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Input channel driver
  always @(posedge clk) begin : drive_proc
    tick_in_t nt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) pwm_expected.push_back(balance_tick(held_tick));
      if (in_valid && !in_ready) begin
        // hold the offered tick
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (tick_q.size() > 0) begin
        nt = tick_q.pop_front();
        held_tick = nt;
        pitch_angle <= nt.pitch_angle;
        pitch_rate <= nt.pitch_rate;
        yaw_rate <= nt.yaw_rate;
        left_count <= nt.left_count;
        right_count <= nt.right_count;
        target_speed <= nt.target_speed;
        target_turn <= nt.target_turn;
        in_valid <= 1'b1;
        send_gap = no_idle ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and scoreboard
  always @(posedge clk) begin : watch_proc
    pwm_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
      hold_off = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pwm_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %0d: L=%0d R=%0d F=%0b",
                     results_seen, left_pwm, right_pwm, fallen);
        end else begin
          want = pwm_expected.pop_front();
          if (left_pwm !== want.left_pwm || right_pwm !== want.right_pwm ||
              fallen !== want.fallen) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at result %0d: expected L=%0d R=%0d F=%0b, got L=%0d R=%0d F=%0b",
                       results_seen, want.left_pwm, want.right_pwm, want.fallen,
                       left_pwm, right_pwm, fallen);
          end
        end
        // long back-pressure so the block stalls its input
        if (results_seen == 400 || results_seen == 1200) hold_off = 200;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = no_idle ? 0 : idle_len();
      end
    end
  end

  task automatic add_tick(int pa, int pr, int yr, int lc, int rc, int ts, int tt);
    tick_in_t t;
    t.pitch_angle = pa;
    t.pitch_rate = pr;
    t.yaw_rate = yr;
    t.left_count = lc;
    t.right_count = rc;
    t.target_speed = ts;
    t.target_turn = tt;
    tick_q.push_back(t);
  endtask

  // Random tick; push_sign picks the direction of a hard push
  task automatic add_random_tick(drive_mode_t mode, int push_sign);
    tick_in_t t;
    int mag;
    t.pitch_angle = $urandom;
    t.pitch_rate = $urandom;
    t.yaw_rate = $urandom;
    t.left_count = $urandom;
    t.right_count = $urandom;
    t.target_speed = $urandom;
    t.target_turn = $urandom;
    if (mode != MODE_NOISE) begin
      if (mode == MODE_PUSH || $urandom_range(0, 19) != 0)
        t.pitch_angle = int'($urandom_range(0, 15360)) - 7680;
      if (mode == MODE_TUMBLE && $urandom_range(0, 5) == 0) begin
        mag = 7681 + $urandom_range(0, 38399);
        t.pitch_angle = $urandom_range(0, 1) ? mag : -mag;
      end
      if ($urandom_range(0, 3) != 0) t.pitch_rate = int'($urandom_range(0, 1048576)) - 524288;
      if ($urandom_range(0, 3) != 0) t.yaw_rate = int'($urandom_range(0, 1048576)) - 524288;
      if ($urandom_range(0, 9) != 0) begin
        t.target_speed = int'($urandom_range(0, 30720)) - 15360;
        t.target_turn = int'($urandom_range(0, 11264)) - 5632;
      end
      if (mode == MODE_PUSH) begin
        t.left_count = push_sign * (32767 - int'($urandom_range(0, 500)));
        t.right_count = push_sign * (32767 - int'($urandom_range(0, 500)));
        t.target_speed = -push_sign * int'($urandom_range(10000, 15360));
      end else if ($urandom_range(0, 7) != 0) begin
        t.left_count = int'($urandom_range(0, 600)) - 300;
        t.right_count = int'($urandom_range(0, 600)) - 300;
      end
    end
    tick_q.push_back(t);
  endtask

  // Wait until the block has nothing in flight
  task automatic wait_idle();
    while (tick_q.size() != 0 || in_valid || pwm_expected.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // Register write; the predictor copy follows at once since the block is idle
  task automatic write_reg(cfg_idx_t idx, longint val);
    longint v;
    int w;
    v = longint'(val[CFG_W-1:0]);
    w = (idx == CFG_BIAS_PITCH || idx == CFG_BIAS_YAW) ? BIAS_W : GAIN_W;
    v = (v <<< (64 - w)) >>> (64 - w);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    gain_r[idx] = v;
  endtask

  task automatic load_gains(longint akp, longint akd, longint skp, longint ski,
                            longint tkp, longint tkd, longint bp, longint by);
    write_reg(CFG_ANGLE_KP, akp);
    write_reg(CFG_ANGLE_KD, akd);
    write_reg(CFG_SPEED_KP, skp);
    write_reg(CFG_SPEED_KI, ski);
    write_reg(CFG_TURN_KP, tkp);
    write_reg(CFG_TURN_KD, tkd);
    write_reg(CFG_BIAS_PITCH, bp);
    write_reg(CFG_BIAS_YAW, by);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus sequence
  initial begin : stim_proc
    int pick;
    int sign;
    drive_mode_t mode;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: tilt limits, field extremes, one full speed-loop window
    add_tick(0, 0, 0, 0, 0, 0, 0);
    add_tick(7680, 0, 0, 0, 0, 0, 0);
    add_tick(-7680, 0, 0, 0, 0, 0, 0);
    add_tick(7681, 0, 0, 5, 5, 0, 0);
    add_tick(-7681, 0, 0, 5, 5, 0, 0);
    add_tick(65535, -1, -1, -1, -1, -1, -1);
    add_tick(-65536, 0, 0, 0, 0, 0, 0);
    add_tick(0, 8388607, -8388608, 0, 0, 0, 0);
    add_tick(0, -8388608, 8388607, 0, 0, 0, 0);
    add_tick(100, 0, 0, 32767, 32767, -16384, 8191);
    add_tick(-100, 0, 0, -32768, -32768, 16383, -8192);
    add_tick(0, 256, -256, 32767, -32768, 15360, 5632);
    add_tick(0, 0, 0, 1000, 1000, -15360, -5632);
    for (int i = 0; i < 8; i++) add_tick(100, 0, 0, 32767, 32767, -15360, 0);
    add_tick(-7681, 0, 0, 0, 0, 0, 0);
    add_tick(0, 0, 0, 0, 0, 0, 0);
    wait_idle();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        1: load_gains(-40960, -2048, -2458, -82, 2458, 4096, 768, -1280);
        2: load_gains(524287, 524287, 524287, 524287, 524287, 524287, 8388607, 8388607);
        3: load_gains(-524288, -524288, -524288, -524288, -524288, -524288,
                      -8388608, -8388608);
        4: load_gains(0, 0, 0, 0, 0, 0, 0, 0);
        5: load_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        6: load_gains(-81920, -410, -1229, -41, 4915, 2048,
                      int'($urandom_range(0, 4096)) - 2048,
                      int'($urandom_range(0, 4096)) - 2048);
        default: begin
          // reset gains
        end
      endcase
      for (int c = 0; c < 5; c++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) mode = MODE_CRUISE;
        else if (pick < 8) mode = MODE_PUSH;
        else if (pick < 9) mode = MODE_TUMBLE;
        else mode = MODE_NOISE;
        sign = $urandom_range(0, 1) ? 1 : -1;
        no_idle = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < 51; i++) add_random_tick(mode, sign);
        // sender pause until all results are back
        if ($urandom_range(0, 2) == 0) wait_idle();
      end
      wait_idle();
    end
    no_idle = 1'b0;

    wait_idle();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pwm_expected.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
